### hw/rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared transaction types, arithmetic constants and pipeline flow types.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int unsigned NUM_STAGES = 7;

	localparam logic [9:0] HUE_CIRCLE   = 10'd360;
	localparam logic [9:0] HUE_CIRCLE_2 = 10'd720;
	localparam logic [6:0] FULL_PCT     = 7'd100;

	// Floor division by 100 for values up to 25500: (x * 5243) >> 19.
	localparam logic [12:0] RECIP_100       = 13'd5243;
	localparam int unsigned RECIP_100_SHIFT = 19;

	// Floor division by 60 for values up to 15045: (x * 69906) >> 22.
	localparam logic [16:0] RECIP_60       = 17'd69906;
	localparam int unsigned RECIP_60_SHIFT = 22;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

	typedef struct packed {
		logic [9:0] hue;
		logic [6:0] saturation;
		logic [6:0] value;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} flow_t;

endpackage

### hw/rtl/hsvrgb_flow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB pipeline flow control
// Holds the stage valid bits and works out which stages may load, so that
// empty stages are filled while the output is stalled.
// ----------------------------------------------------------------------------
module hsvrgb_flow (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                out_stall,
	output hsvrgb_pkg::flow_t   flow
);
	import hsvrgb_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   adv;

	always_comb begin
		adv[NUM_STAGES] = !out_stall;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall = !adv[0];
	assign flow.en  = adv[NUM_STAGES-1:0];
	assign flow.vld = vld_q;

endmodule

### hw/rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Seven-stage pipeline turning hue, saturation and value into 8-bit RGB.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  hsv      input      hsv_valid / hsv_stall    hsv_t (hue, saturation, value)
//  rgb      output     rgb_valid / rgb_stall    rgb_t (red, green, blue)
//
// One transaction enters per cycle while hsv_stall is low; each result passes through every stage in order.
// The stage split is set by three constant divisions, done as reciprocal products,
// and the two products that feed them.
// Reset clears only the stage valid bits; the pipeline is then empty.
// A stalled output holds stage seven; earlier empty stages still take new data.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_stall,
	input  hsvrgb_pkg::hsv_t  hsv,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output hsvrgb_pkg::rgb_t  rgb
);
	import hsvrgb_pkg::*;

	flow_t flow;

	logic [8:0]  hue_s1;
	logic [6:0]  sat_s1;
	logic [6:0]  val_s1;

	logic [7:0]  hi_s2;
	logic [6:0]  inv_s2;
	sector_t     sector_s2;
	logic [5:0]  frac_s2;

	logic [14:0] prod_s3;
	logic [7:0]  hi_s3;
	sector_t     sector_s3;
	logic [5:0]  frac_s3;

	logic [7:0]  lo_s4;
	logic [7:0]  hi_s4;
	sector_t     sector_s4;
	logic [5:0]  frac_s4;

	logic [13:0] dprod_s5;
	logic [7:0]  lo_s5;
	logic [7:0]  hi_s5;
	sector_t     sector_s5;

	logic [7:0]  adj_s6;
	logic [7:0]  lo_s6;
	logic [7:0]  hi_s6;
	sector_t     sector_s6;

	rgb_t        rgb_s7;

	logic [9:0]  hue_red;
	logic [6:0]  sat_clamp;
	logic [6:0]  val_clamp;
	logic [14:0] val_scaled;
	logic [27:0] hi_prod;
	sector_t     sector_c;
	logic [8:0]  sector_base;
	logic [8:0]  frac_wide;
	logic [27:0] lo_prod;
	logic [7:0]  diff;
	logic [30:0] adj_prod;
	logic [7:0]  up;
	logic [7:0]  down;
	rgb_t        rgb_c;

	hsvrgb_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv_valid),
		.in_stall  (hsv_stall),
		.out_stall (rgb_stall),
		.flow      (flow)
	);

	always_comb begin
		priority if (hsv.hue >= HUE_CIRCLE_2) begin
			hue_red = hsv.hue - HUE_CIRCLE_2;
		end else if (hsv.hue >= HUE_CIRCLE) begin
			hue_red = hsv.hue - HUE_CIRCLE;
		end else begin
			hue_red = hsv.hue;
		end
		sat_clamp = (hsv.saturation > FULL_PCT) ? FULL_PCT : hsv.saturation;
		val_clamp = (hsv.value > FULL_PCT) ? FULL_PCT : hsv.value;
	end

	always_ff @(posedge clk) begin
		if (flow.en[0]) begin
			hue_s1 <= hue_red[8:0];
			sat_s1 <= sat_clamp;
			val_s1 <= val_clamp;
		end
	end

	always_comb begin
		val_scaled = {val_s1, 8'b0} - 15'(val_s1);
		hi_prod    = 28'(val_scaled) * 28'(RECIP_100);
		priority if (hue_s1 >= 9'd300) begin
			sector_c    = SEC_MAGENTA_RED;
			sector_base = 9'd300;
		end else if (hue_s1 >= 9'd240) begin
			sector_c    = SEC_BLUE_MAGENTA;
			sector_base = 9'd240;
		end else if (hue_s1 >= 9'd180) begin
			sector_c    = SEC_CYAN_BLUE;
			sector_base = 9'd180;
		end else if (hue_s1 >= 9'd120) begin
			sector_c    = SEC_GREEN_CYAN;
			sector_base = 9'd120;
		end else if (hue_s1 >= 9'd60) begin
			sector_c    = SEC_YELLOW_GREEN;
			sector_base = 9'd60;
		end else begin
			sector_c    = SEC_RED_YELLOW;
			sector_base = 9'd0;
		end
		frac_wide = hue_s1 - sector_base;
	end

	always_ff @(posedge clk) begin
		if (flow.en[1]) begin
			hi_s2     <= hi_prod[RECIP_100_SHIFT +: 8];
			inv_s2    <= FULL_PCT - sat_s1;
			sector_s2 <= sector_c;
			frac_s2   <= frac_wide[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (flow.en[2]) begin
			prod_s3   <= 15'(hi_s2) * 15'(inv_s2);
			hi_s3     <= hi_s2;
			sector_s3 <= sector_s2;
			frac_s3   <= frac_s2;
		end
	end

	assign lo_prod = 28'(prod_s3) * 28'(RECIP_100);

	always_ff @(posedge clk) begin
		if (flow.en[3]) begin
			lo_s4     <= lo_prod[RECIP_100_SHIFT +: 8];
			hi_s4     <= hi_s3;
			sector_s4 <= sector_s3;
			frac_s4   <= frac_s3;
		end
	end

	assign diff = hi_s4 - lo_s4;

	always_ff @(posedge clk) begin
		if (flow.en[4]) begin
			dprod_s5  <= 14'(diff) * 14'(frac_s4);
			lo_s5     <= lo_s4;
			hi_s5     <= hi_s4;
			sector_s5 <= sector_s4;
		end
	end

	assign adj_prod = 31'(dprod_s5) * 31'(RECIP_60);

	always_ff @(posedge clk) begin
		if (flow.en[5]) begin
			adj_s6    <= adj_prod[RECIP_60_SHIFT +: 8];
			lo_s6     <= lo_s5;
			hi_s6     <= hi_s5;
			sector_s6 <= sector_s5;
		end
	end

	always_comb begin
		up   = lo_s6 + adj_s6;
		down = hi_s6 - adj_s6;
		unique case (sector_s6)
			SEC_RED_YELLOW: begin
				rgb_c = '{red: hi_s6, green: up, blue: lo_s6};
			end
			SEC_YELLOW_GREEN: begin
				rgb_c = '{red: down, green: hi_s6, blue: lo_s6};
			end
			SEC_GREEN_CYAN: begin
				rgb_c = '{red: lo_s6, green: hi_s6, blue: up};
			end
			SEC_CYAN_BLUE: begin
				rgb_c = '{red: lo_s6, green: down, blue: hi_s6};
			end
			SEC_BLUE_MAGENTA: begin
				rgb_c = '{red: up, green: lo_s6, blue: hi_s6};
			end
			default: begin
				rgb_c = '{red: hi_s6, green: lo_s6, blue: down};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (flow.en[6]) begin
			rgb_s7 <= rgb_c;
		end
	end

	assign rgb_valid = flow.vld[NUM_STAGES-1];
	assign rgb       = rgb_s7;

	// The input is held off only while a result waits at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> (rgb_valid && rgb_stall))
		else $error("input stalled without an output stall");

	// A full pipeline behind a stalled output must hold off the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		((&flow.vld) && rgb_stall) |-> hsv_stall)
		else $error("input taken into a full stalled pipeline");

	// An accepted transaction occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && !hsv_stall) |=> flow.vld[0])
		else $error("accepted transaction lost at the first stage");

	// A result that leaves the pipeline came from a valid stage six.
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rgb_valid)) |-> $past(flow.vld[NUM_STAGES-2]))
		else $error("result appeared without a valid predecessor");

endmodule

### sim/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives hue, saturation and value transactions into the converter and checks
// every red, green, blue result against an integer colour predictor held in
// order in a queue. Directed corners cover every hue sector boundary, hue
// wrap-around, clamped percentages and zero saturation; random traffic then
// runs under several mixes of sender gaps and receiver stalls, plus one long
// output hold that fills the pipeline and stalls its input.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
	import hsvrgb_pkg::*;

	localparam int unsigned FULL_SCALE  = 255;
	localparam int unsigned SECTOR_SPAN = 60;

	logic clk;
	logic arst_n    = 1'b0;
	logic hsv_valid = 1'b0;
	logic hsv_stall;
	hsv_t hsv       = '0;
	logic rgb_valid;
	logic rgb_stall = 1'b0;
	rgb_t rgb;

	rgb_t        expected_rgb[$];
	rgb_t        want;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned hold_left     = 0;
	int unsigned errors        = 0;
	int unsigned colours_sent  = 0;
	int unsigned colours_seen  = 0;

	hsv_to_rgb_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("hsv_to_rgb_converter test failed");
		$finish;
	end

	function automatic hsv_t colour(input int unsigned h, input int unsigned s,
			input int unsigned v);
		hsv_t c;
		c.hue        = 10'(h);
		c.saturation = 7'(s);
		c.value      = 7'(v);
		return c;
	endfunction

	function automatic rgb_t hsv_colour(input hsv_t c);
		int unsigned h, s, v, hi, lo, frac, adj, up, down;
		sector_t     sec;
		rgb_t        o;
		h    = c.hue % HUE_CIRCLE;
		s    = (c.saturation > FULL_PCT) ? FULL_PCT : c.saturation;
		v    = (c.value > FULL_PCT) ? FULL_PCT : c.value;
		hi   = v * FULL_SCALE / FULL_PCT;
		lo   = hi * (FULL_PCT - s) / FULL_PCT;
		sec  = sector_t'(h / SECTOR_SPAN);
		frac = h % SECTOR_SPAN;
		adj  = (hi - lo) * frac / SECTOR_SPAN;
		up   = lo + adj;
		down = hi - adj;
		case (sec)
			SEC_RED_YELLOW:   o = '{8'(hi), 8'(up), 8'(lo)};
			SEC_YELLOW_GREEN: o = '{8'(down), 8'(hi), 8'(lo)};
			SEC_GREEN_CYAN:   o = '{8'(lo), 8'(hi), 8'(up)};
			SEC_CYAN_BLUE:    o = '{8'(lo), 8'(down), 8'(hi)};
			SEC_BLUE_MAGENTA: o = '{8'(up), 8'(lo), 8'(hi)};
			default:          o = '{8'(hi), 8'(lo), 8'(down)};
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// Called just after a rising edge; returns at the edge that accepted the transaction.
	task automatic send_colour(input hsv_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			hsv_valid <= 1'b0;
			@(posedge clk);
		end
		hsv_valid <= 1'b1;
		hsv       <= c;
		@(posedge clk);
		while (hsv_stall) @(posedge clk);
		expected_rgb.push_back(hsv_colour(c));
		colours_sent++;
	endtask

	task automatic wait_for_results();
		hsv_valid <= 1'b0;
		while (expected_rgb.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_colours(input int unsigned count);
		hsv_t c;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(3) != 0)
				c = colour($urandom_range(359), $urandom_range(100), $urandom_range(100));
			else
				c = 24'($urandom);
			send_colour(c);
		end
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			rgb_stall <= 1'b1;
			hold_left--;
		end else begin
			rgb_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (rgb_valid && !rgb_stall) begin
			colours_seen++;
			if (expected_rgb.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", rgb));
			end else begin
				want = expected_rgb.pop_front();
				if (rgb.red !== want.red)
					report_mismatch($sformatf("red %0d, expected %0d", rgb.red, want.red));
				if (rgb.green !== want.green)
					report_mismatch($sformatf("green %0d, expected %0d", rgb.green,
						want.green));
				if (rgb.blue !== want.blue)
					report_mismatch($sformatf("blue %0d, expected %0d", rgb.blue, want.blue));
			end
		end
	end

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_colour(colour(0, 100, 100));
		send_colour(colour(59, 100, 100));
		send_colour(colour(60, 100, 100));
		send_colour(colour(119, 100, 100));
		send_colour(colour(120, 100, 100));
		send_colour(colour(179, 80, 90));
		send_colour(colour(180, 100, 100));
		send_colour(colour(239, 50, 70));
		send_colour(colour(240, 100, 100));
		send_colour(colour(299, 100, 100));
		send_colour(colour(300, 100, 100));
		send_colour(colour(359, 100, 100));
		send_colour(colour(360, 100, 100));
		send_colour(colour(719, 75, 60));
		send_colour(colour(720, 100, 100));
		send_colour(colour(1023, 127, 127));
		send_colour(colour(1023, 0, 0));
		send_colour(colour(45, 0, 100));
		send_colour(colour(200, 0, 37));
		send_colour(colour(90, 101, 101));
		send_colour(colour(270, 127, 55));
		send_colour(colour(330, 33, 127));
		send_colour(colour(0, 0, 0));
		send_colour(colour(150, 1, 1));
		wait_for_results();
	endtask

	task automatic test_streaming();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_random_colours(130);
		wait_for_results();
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 48;
		stall_pct     = 0;
		send_random_colours(120);
		wait_for_results();
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		stall_pct     = 48;
		send_random_colours(120);
		wait_for_results();
	endtask

	task automatic test_both_idle();
		send_idle_pct = 38;
		stall_pct     = 38;
		send_random_colours(130);
		wait_for_results();
	endtask

	// The output is held for a long stretch so that the pipeline fills and stalls its input.
	task automatic test_output_hold();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left     = 150;
		send_random_colours(50);
		wait_for_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_streaming();
		test_sender_gaps();
		test_output_hold();
		test_receiver_stalls();
		test_both_idle();
		stall_pct = 0;
		repeat (NUM_STAGES + 10) @(posedge clk);
		$display("Sent %0d colours and checked %0d results: sector corners, hue wrap,",
			colours_sent, colours_seen);
		$display("clamped percentages, four idling mixes and a long output hold.");
		if (errors == 0)
			$display("hsv_to_rgb_converter test passed");
		else
			$display("hsv_to_rgb_converter test failed");
		$finish;
	end

endmodule
